/* rtl/core/mf15_pkg.sv */
// Package: minifloat format constants and pipeline stage types.
package mf15_pkg;
  localparam int unsigned FracWidth = 8;
  localparam int unsigned ExpWidth  = 6;
  localparam int unsigned ExpBias   = 31;
  localparam int unsigned SignPos   = ExpWidth + FracWidth;
  localparam int unsigned MiniWidth = SignPos + 1;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_e;

  // Stage one to two: classified operand.
  typedef struct packed {
    kind_e        kind;
    logic         sign;
    logic         is_zero;
    logic         is_sat;
    logic [23:0]  sig;
    logic [9:0]   exp;
  } st1_t;

  // Stage two to three: normalized significand.
  typedef struct packed {
    kind_e        kind;
    logic         sign;
    logic         is_zero;
    logic         is_sat;
    logic [23:0]  sig;
    logic [9:0]   exp;
  } st2_t;
endpackage

/* rtl/core/minifloat15_convert_top.sv */
// Top level: three-stage float32 / minifloat converter.
// One beat enters per cycle while in_stall_o is low and passes through
// s1_q, s2_q and res_q. The stages are the operand classify and unpack,
// the leading-zero normalize, and the packing with the truncating denormal
// shift and saturation. A result that waits under out_stall_i holds the
// whole pipeline, bubbles included, and raises in_stall_o in the same cycle.
module minifloat15_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o,
  output logic        out_of_range_o
);
  logic         v1_q, v2_q, v3_q;
  mf15_pkg::st1_t s1_d, s1_q;
  mf15_pkg::st2_t s2_d, s2_q;
  logic [31:0]  res_d, res_q;
  logic         oor_d, oor_q;
  logic         adv;
  logic [4:0]   lz;

  assign adv        = !(v3_q && out_stall_i);
  assign in_stall_o = !adv;

  // Classify and unpack the operand.
  always_comb begin
    logic [7:0] e8;
    logic [22:0] m;
    logic [7:0] fr;
    logic [5:0] ef;
    e8 = operand_bits_i[30:23];
    m  = operand_bits_i[22:0];
    fr = operand_bits_i[7:0];
    ef = operand_bits_i[13:8];
    s1_d.kind = mf15_pkg::kind_e'(kind_i);
    if (kind_i == mf15_pkg::KIND_ENCODE) begin
      s1_d.sign    = operand_bits_i[31];
      s1_d.is_sat  = (e8 == 8'hFF);
      s1_d.is_zero = (e8 == 8'd0) && (m == 23'd0);
      s1_d.sig     = (e8 == 8'd0) ? {1'b0, m} : {1'b1, m};
      s1_d.exp     = (e8 == 8'd0) ? 10'(-126) : 10'({2'b00, e8} - 10'd127);
    end else begin
      s1_d.sign    = operand_bits_i[14];
      s1_d.is_sat  = 1'b0;
      s1_d.is_zero = (ef == 6'd0) && (fr == 8'd0);
      s1_d.sig     = (ef == 6'd0) ? {1'b0, fr, 15'd0} : {1'b1, fr, 15'd0};
      s1_d.exp     = (ef == 6'd0) ? 10'(-30) : 10'({4'd0, ef} - 10'd31);
    end
  end

  // Normalize to a leading one at bit 23.
  mf15_lzc u_lzc (.sig_i(s1_q.sig), .cnt_o(lz));

  always_comb begin
    s2_d     = s1_q;
    s2_d.sig = s1_q.sig << lz;
    s2_d.exp = s1_q.exp - {5'd0, lz};
  end

  // Pack the result.
  always_comb begin
    logic signed [9:0] me;
    logic [9:0] sh;
    logic [23:0] dn;
    me    = $signed(s2_q.exp) + 10'sd31;
    sh    = 10'd16 - me;
    dn    = (sh >= 10'd24) ? 24'd0 : (s2_q.sig >> sh[4:0]);
    oor_d = 1'b0;
    res_d = 32'd0;
    if (s2_q.kind == mf15_pkg::KIND_DECODE) begin
      if (s2_q.is_zero) res_d = {s2_q.sign, 31'd0};
      else res_d = {s2_q.sign, 8'(s2_q.exp + 10'd127), s2_q.sig[22:0]};
    end else if (s2_q.is_sat || (!s2_q.is_zero && me > 10'sd63)) begin
      oor_d = 1'b1;
      res_d = {17'd0, s2_q.sign, 14'h3FFF};
    end else if (s2_q.is_zero) begin
      res_d = {17'd0, s2_q.sign, 14'd0};
    end else if (me >= 10'sd1) begin
      res_d = {17'd0, s2_q.sign, me[5:0], s2_q.sig[22:15]};
    end else begin
      res_d = {17'd0, s2_q.sign, 6'd0, dn[7:0]};
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      res_q <= res_d;
      oor_q <= oor_d;
    end
  end

  assign out_valid_o    = v3_q;
  assign result_bits_o  = res_q;
  assign out_of_range_o = oor_q;

  // Decoding never flags range.
  a_dec_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && adv && s2_q.kind == mf15_pkg::KIND_DECODE) |=> !out_of_range_o)
    else $error("decode flagged out of range");
  // Held result stays while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_bits_o)))
    else $error("stalled result changed");
  // Encode results fit the minifloat width.
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && adv && s2_q.kind == mf15_pkg::KIND_ENCODE) |=> (result_bits_o[31:15] == 17'd0))
    else $error("encode result too wide");
endmodule

/* rtl/core/mf15_lzc.sv */
// Leading zero count of a 24-bit significand.
module mf15_lzc (
  input  logic [23:0] sig_i,
  output logic [4:0]  cnt_o
);
  always_comb begin
    cnt_o = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (sig_i[i]) cnt_o = 5'(23 - i);
    end
  end
endmodule

/* tb/tb.sv */
// Testbench for the float32 / minifloat converter: scoreboard-checked random and directed beats.
`timescale 1ns / 1ps

module tb;
  localparam int unsigned NumRandom = 1850;
  localparam int unsigned WatchLimit = 2000;

  typedef struct {
    logic [31:0] bits;
    logic        oor;
  } conv_result_t;

  // Predict conversion results and compare them with the output beats.
  class conv_scoreboard;
    conv_result_t pending_q[$];
    int mismatches;

    function automatic conv_result_t encode_f32(logic [31:0] x);
      conv_result_t r;
      logic        s;
      logic [7:0]  e8;
      logic [22:0] m;
      logic [23:0] sig;
      int          e;
      int          me;
      int          sh;
      logic [14:0] sat;
      s = x[31];
      e8 = x[30:23];
      m = x[22:0];
      sat = {s, {mf15_pkg::ExpWidth{1'b1}}, {mf15_pkg::FracWidth{1'b1}}};
      r.oor = 1'b0;
      r.bits = '0;
      if (e8 == 8'hFF) begin
        r.oor = 1'b1;
        r.bits = {17'b0, sat};
        return r;
      end
      if (e8 == 0 && m == 0) begin
        r.bits = {17'b0, s, 14'b0};
        return r;
      end
      if (e8 == 0) begin
        sig = {1'b0, m};
        e = -126;
        while (!sig[23]) begin
          sig = sig << 1;
          e--;
        end
      end else begin
        sig = {1'b1, m};
        e = int'(e8) - 127;
      end
      me = e + mf15_pkg::ExpBias;
      if (me > (1 << mf15_pkg::ExpWidth) - 1) begin
        r.oor = 1'b1;
        r.bits = {17'b0, sat};
      end else if (me >= 1) begin
        r.bits = {17'b0, s, me[5:0], sig[22:15]};
      end else begin
        sh = 24 - mf15_pkg::FracWidth - me;
        r.bits = {17'b0, s, 6'b0, (sh >= 32) ? 8'h00 : 8'(sig >> sh)};
      end
      return r;
    endfunction

    function automatic conv_result_t decode_mini(logic [31:0] x);
      conv_result_t r;
      logic       s;
      logic [5:0] ef;
      logic [7:0] frac;
      logic [8:0] f;
      int         p;
      int         t;
      int         fe;
      s = x[14];
      ef = x[13:8];
      frac = x[7:0];
      r.oor = 1'b0;
      if (ef == 0 && frac == 0) begin
        r.bits = {s, 31'b0};
        return r;
      end
      if (ef == 0) begin
        f = {1'b0, frac};
        p = 1 - mf15_pkg::ExpBias - mf15_pkg::FracWidth;
      end else begin
        f = {1'b1, frac};
        p = int'(ef) - mf15_pkg::ExpBias - mf15_pkg::FracWidth;
      end
      t = 0;
      while (t < 31 && (32'(f) >> (t + 1)) != 0) t++;
      fe = t + p + 127;
      r.bits = {s, fe[7:0], 23'((32'(f) << (23 - t)))};
      return r;
    endfunction

    function void note_input(logic kind, logic [31:0] bits);
      if (kind == mf15_pkg::KIND_ENCODE) pending_q.push_back(encode_f32(bits));
      else pending_q.push_back(decode_mini(bits));
    endfunction

    function void check_result(logic [31:0] bits, logic oor);
      conv_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h oor %b", bits, oor);
        return;
      end
      want = pending_q.pop_front();
      if (bits !== want.bits || oor !== want.oor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%b actual %h/%b", want.bits, want.oor, bits, oor);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [31:0] operand_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_bits_o;
  logic        out_of_range_o;
  logic        stim_done = 1'b0;
  int          idle_cycles = 0;

  conv_scoreboard sb = new();

  minifloat15_convert_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // Send one beat after the given gap and hold it until accepted.
  task automatic send_beat(logic kind, logic [31:0] bits, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    operand_bits_i <= bits;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(kind, bits);
  endtask

  // Draw a float32 pattern biased toward the minifloat range.
  function automatic logic [31:0] rand_f32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0, 1, 2: v[30:23] = 8'($urandom_range(127 - 40, 127 + 34));
      3: v[30:23] = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
      default: ;
    endcase
    return v;
  endfunction

  // Drive the input side.
  initial begin
    logic [31:0] directed [$];
    int gap;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
                 32'h3F80_0000, 32'hBFFF_FFFF, 32'h5F80_0000, 32'h5F7F_FFFF,
                 32'h3080_0000, 32'h3000_0000, 32'h2F7F_FFFF, 32'hB0FF_8000,
                 32'h7F7F_FFFF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_beat(mf15_pkg::KIND_ENCODE, directed[i], 0);
    foreach (directed[i]) send_beat(mf15_pkg::KIND_DECODE, directed[i] ^ 32'(i << 9), 0);
    for (int n = 0; n < NumRandom; n++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (n % 300 < 60) gap = 0;
      if ($urandom_range(0, 1)) send_beat(mf15_pkg::KIND_ENCODE, rand_f32(), gap);
      else send_beat(mf15_pkg::KIND_DECODE, $urandom, gap);
    end
    in_valid_i <= 1'b0;
    stim_done <= 1'b1;
  end

  // Drive stall on the output side.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check results and watch for progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(result_bits_o, out_of_range_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // End the run.
  initial begin
    @(posedge rst_ni);
    while (!(stim_done && sb.pending_q.size() == 0) && idle_cycles < WatchLimit)
      @(posedge clk_i);
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
    end else begin
      repeat (20) @(posedge clk_i);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
